### hw/rtl/kinematic_aabb_sweep_assert.svh
// ----------------------------------------------------------------------------
// kinematic_aabb_sweep_assert.svh
// Assertion macros shared by the kinematic box sweep RTL.
// ----------------------------------------------------------------------------
`ifndef KINEMATIC_AABB_SWEEP_ASSERT_SVH
`define KINEMATIC_AABB_SWEEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KAS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kinematic_aabb_sweep assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kinematic_aabb_sweep assertion failed");

`endif

### hw/rtl/kas_pkg.sv
// ----------------------------------------------------------------------------
// kas_pkg
// Types, constants and helpers of the kinematic box sweep.
// ----------------------------------------------------------------------------
package kas_pkg;

  // Default build settings
  localparam int MAX_BOXES_DEF    = 64;
  localparam int BISECT_STEPS_DEF = 20;
  localparam int FRAC_BITS_DEF    = 16;

  // Position width inside a step (center + move + half + two skins)
  localparam int PW = 40;

  // One stored box: {one_way, high_y, high_x, low_y, low_x}
  localparam int BOX_W = 129;

  // Commands; the spare code behaves as a step
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_STEPPED = 2'd0;
  localparam logic [1:0] STS_STORED  = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;
  localparam logic [1:0] STS_CLEARED = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_GRAVITY_X = 2'd0;
  localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
  localparam logic [1:0] REG_TIME_STEP = 2'd2;
  localparam logic [1:0] REG_MARGIN    = 2'd3;

  // Register reset values
  localparam logic [16:0] TIME_STEP_RST = 17'd1092;
  localparam logic [15:0] MARGIN_RST    = 16'd7;

  // Overlap query issued to the scan unit
  typedef struct packed {
    logic signed [PW-1:0] lx;
    logic signed [PW-1:0] ly;
    logic signed [PW-1:0] hx;
    logic signed [PW-1:0] hy;
    logic                 down;
    logic signed [PW-1:0] sb;
  } qry_req_t;

  // Scan unit answer
  typedef struct packed {
    logic done;
    logic blocked;
  } qry_rsp_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### hw/rtl/kas_if.sv
// ----------------------------------------------------------------------------
// kas_if
// Valid/ready channels of the kinematic box sweep: command and result.
// ----------------------------------------------------------------------------
interface kas_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        half_x;
  logic [30:0]        half_y;
  logic               platform_one_way;
  logic signed [31:0] speed_x;
  logic signed [31:0] speed_y;
  logic signed [31:0] gravity_factor;
  logic [30:0]        skin_width;

  modport source(output valid, cmd, center_x, center_y, half_x, half_y,
                 platform_one_way, speed_x, speed_y, gravity_factor, skin_width,
                 input ready);
  modport sink(input valid, cmd, center_x, center_y, half_x, half_y,
               platform_one_way, speed_x, speed_y, gravity_factor, skin_width,
               output ready);
endinterface

interface kas_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] new_center_x;
  logic signed [31:0] new_center_y;
  logic signed [31:0] new_speed_x;
  logic signed [31:0] new_speed_y;
  logic               grounded;
  logic               hit_x;
  logic               hit_y;

  modport source(output valid, status, new_center_x, new_center_y, new_speed_x,
                 new_speed_y, grounded, hit_x, hit_y, input ready);
  modport sink(input valid, status, new_center_x, new_center_y, new_speed_x,
               new_speed_y, grounded, hit_x, hit_y, output ready);
endinterface

### hw/rtl/kas_ram.sv
// ----------------------------------------------------------------------------
// kas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/kas_query.sv
// ----------------------------------------------------------------------------
// kas_query
// Overlap scan: walks the box table one entry a cycle and reports a block.
// ----------------------------------------------------------------------------
module kas_query import kas_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int CW        = $clog2(MAX_BOXES + 1),
  parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  qry_req_t         req,
  input  logic [15:0]      margin,
  input  logic [CW-1:0]    count,
  output logic [AW-1:0]    raddr,
  input  logic [BOX_W-1:0] rdata,
  output qry_rsp_t         rsp
);

  logic           busy_r, busy_nxt;
  logic           pend_r, pend_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  qry_req_t       req_r;

  logic signed [PW-1:0] blx, bly, bhx, bhy, top_lim;
  logic                 bow, ovl, hit;

  // Unpack the entry read last cycle
  always_comb begin
    blx     = PW'($signed(rdata[31:0]));
    bly     = PW'($signed(rdata[63:32]));
    bhx     = PW'($signed(rdata[95:64]));
    bhy     = PW'($signed(rdata[127:96]));
    bow     = rdata[128];
    top_lim = bhy - $signed({{(PW-16){1'b0}}, margin});
    ovl     = (req_r.lx < bhx) && (blx < req_r.hx) &&
              (req_r.ly < bhy) && (bly < req_r.hy);
    hit     = pend_r && ovl && (!bow || (req_r.down && !(req_r.sb < top_lim)));
  end

  assign raddr       = idx_r[AW-1:0];
  assign rsp.blocked = hit;
  assign rsp.done    = busy_r && (hit || (idx_r == count));

  // Advance the scan, stop on the first blocking box or the table end
  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = 1'b0;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (rsp.done) begin
        busy_nxt = 1'b0;
      end else begin
        pend_nxt = 1'b1;
        idx_nxt  = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Hold the query for the whole scan
  always_ff @(posedge clk) begin
    if (start) req_r <= req;
  end

endmodule

### hw/rtl/kinematic_aabb_sweep.sv
// ----------------------------------------------------------------------------
// kinematic_aabb_sweep
// Kinematic box controller swept against a RAM table of static boxes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_ch     in   valid/ready       cmd, center, half, one-way, speed, gravity factor, skin
//  out_ch    out  valid/ready       status, new center, new speed, flags
//  cfg_*     in   APB, pready = 1   gravity x/y, time step, one-way margin
//
// A step runs up to 2 * (BISECT_STEPS + 1) + 1 overlap scans over the stored boxes;
// the one-entry-per-cycle table read sets how long each scan runs.
// Reset is synchronous active low and empties the table; no clearing pass.
// A new item is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`include "kinematic_aabb_sweep_assert.svh"

module kinematic_aabb_sweep import kas_pkg::*; #(
  parameter int MAX_BOXES    = MAX_BOXES_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kas_in_if.sink      in_ch,
  kas_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BW = BISECT_STEPS + 1;
  localparam int IW = $clog2(BISECT_STEPS + 1);

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001, ST_DEC = 22'h000002, ST_GY  = 22'h000004,
    ST_TY   = 22'h000008, ST_VY  = 22'h000010, ST_GX  = 22'h000020,
    ST_TX   = 22'h000040, ST_VX  = 22'h000080, ST_DX  = 22'h000100,
    ST_DXS  = 22'h000200, ST_DY  = 22'h000400, ST_DYS = 22'h000800,
    ST_SW0  = 22'h001000, ST_SWW = 22'h002000, ST_BM  = 22'h004000,
    ST_BQ   = 22'h008000, ST_BW  = 22'h010000, ST_AM  = 22'h020000,
    ST_AD   = 22'h040000, ST_GND = 22'h080000, ST_GW  = 22'h100000,
    ST_OUT  = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [31:0] gx_r, gy_r;
  logic [16:0]        ts_r;
  logic [15:0]        mg_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= '0;
      gy_r <= '0;
      ts_r <= TIME_STEP_RST;
      mg_r <= MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_GRAVITY_X: gx_r <= cfg_pwdata;
        REG_GRAVITY_Y: gy_r <= cfg_pwdata;
        REG_TIME_STEP: ts_r <= cfg_pwdata[16:0];
        REG_MARGIN:    mg_r <= cfg_pwdata[15:0];
        default:       gx_r <= gx_r;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_GRAVITY_X: cfg_prdata = gx_r;
      REG_GRAVITY_Y: cfg_prdata = gy_r;
      REG_TIME_STEP: cfg_prdata = 32'(ts_r);
      REG_MARGIN:    cfg_prdata = 32'(mg_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Item and step state
  logic [1:0]           cmd_r;
  logic                 ow_r;
  logic signed [PW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, sb_r;
  logic [30:0]          hx_r, hy_r, skin_r;
  logic signed [31:0]   vx_r, vx_nxt, vy_r, vy_nxt, gf_r, delta_r, delta_nxt;
  logic                 axis_r, axis_nxt;
  logic [BW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [IW-1:0]        it_r, it_nxt;
  logic                 hitx_r, hitx_nxt, hity_r, hity_nxt, gnd_r, gnd_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [65:0]   prod_r, prod_nxt;
  logic signed [32:0]   mul_a, mul_b;

  // Output register
  logic               ov_r, ov_nxt, load_out;
  logic [1:0]         sts_r, sts_nxt;
  logic signed [31:0] ocx_r, ocy_r, ovx_r, ovy_r;
  logic               ognd_r, ohx_r, ohy_r;

  // Table RAM and scan unit
  logic             ram_we;
  logic [BOX_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]    ram_raddr;
  logic             q_start;
  qry_req_t         q_req;
  qry_rsp_t         q_rsp;

  kas_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  kas_query #(.MAX_BOXES(MAX_BOXES), .CW(CW), .AW(AW)) u_query (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_start),
    .req   (q_req),
    .margin(mg_r),
    .count (cnt_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .rsp   (q_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign mid         = BW'((BW+1)'(lo_r) + (BW+1)'(hi_r) >> 1);

  // New box edges, saturated
  assign ram_wdata = {ow_r,
                      sat32(72'(cy_r) + 72'(hy_r)), sat32(72'(cx_r) + 72'(hx_r)),
                      sat32(72'(cy_r) - 72'(hy_r)), sat32(72'(cx_r) - 72'(hx_r))};
  assign ram_we    = (state_r == ST_DEC) && (cmd_r == CMD_ADD) &&
                     (cnt_r != CW'(MAX_BOXES));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_GY: begin mul_a = 33'(gy_r); mul_b = 33'(gf_r); end
      ST_GX: begin mul_a = 33'(gx_r); mul_b = 33'(gf_r); end
      ST_TY, ST_TX: begin
        mul_a = 33'(sat32(72'(prod_r >>> FRAC_BITS)));
        mul_b = $signed(33'(ts_r));
      end
      ST_DX: begin mul_a = 33'(vx_r); mul_b = $signed(33'(ts_r)); end
      ST_DY: begin mul_a = 33'(vy_r); mul_b = $signed(33'(ts_r)); end
      ST_BM: begin mul_a = 33'(delta_r); mul_b = $signed(33'(mid)); end
      ST_AM: begin mul_a = 33'(delta_r); mul_b = $signed(33'(lo_r)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Overlap query for the probe or the ground strip
  logic signed [PW-1:0] off, tx, ty;
  always_comb begin
    off = (state_r == ST_SW0) ? PW'(delta_r) : PW'(prod_r >>> BISECT_STEPS);
    tx  = (axis_r == 1'b0) ? cx_r + off : cx_r;
    ty  = (axis_r == 1'b1) ? cy_r + off : cy_r;
    q_start = (state_r == ST_SW0 && delta_r != 0) || (state_r == ST_BQ) ||
              (state_r == ST_GND);
    if (state_r == ST_GND) begin
      q_req.lx   = cx_r - $signed(PW'(hx_r));
      q_req.ly   = cy_r - $signed(PW'(hy_r)) - $signed(PW'({skin_r, 1'b0}));
      q_req.hx   = cx_r + $signed(PW'(hx_r));
      q_req.hy   = cy_r + $signed(PW'(hy_r));
      q_req.down = 1'b1;
      q_req.sb   = cy_r - $signed(PW'(hy_r));
    end else begin
      q_req.lx   = tx - $signed(PW'(hx_r));
      q_req.ly   = ty - $signed(PW'(hy_r));
      q_req.hx   = tx + $signed(PW'(hx_r));
      q_req.hy   = ty + $signed(PW'(hy_r));
      q_req.down = axis_r && delta_r[31];
      q_req.sb   = sb_r;
    end
  end

  // Back-off after the bisection
  logic signed [PW-1:0] adv, adv2;
  always_comb begin
    adv  = PW'(prod_r >>> BISECT_STEPS);
    adv2 = adv[PW-1] ? adv + $signed(PW'(skin_r)) : adv - $signed(PW'(skin_r));
  end

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    delta_nxt = delta_r;
    axis_nxt  = axis_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    it_nxt    = it_r;
    hitx_nxt  = hitx_r;
    hity_nxt  = hity_r;
    gnd_nxt   = gnd_r;
    cnt_nxt   = cnt_r;
    sts_nxt   = sts_r;
    prod_nxt  = mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_DEC;
      ST_DEC: begin
        hitx_nxt = 1'b0;
        hity_nxt = 1'b0;
        gnd_nxt  = 1'b0;
        if (cmd_r == CMD_CLEAR) begin
          cnt_nxt   = '0;
          sts_nxt   = STS_CLEARED;
          state_nxt = ST_OUT;
        end else if (cmd_r == CMD_ADD) begin
          if (ram_we) begin
            cnt_nxt = cnt_r + 1'b1;
            sts_nxt = STS_STORED;
          end else begin
            sts_nxt = STS_FULL;
          end
          state_nxt = ST_OUT;
        end else begin
          sts_nxt   = STS_STEPPED;
          state_nxt = ST_GY;
        end
      end
      ST_GY: state_nxt = ST_TY;
      ST_TY: state_nxt = ST_VY;
      ST_VY: begin
        vy_nxt    = sat32(72'(vy_r) + 72'(prod_r >>> FRAC_BITS));
        state_nxt = ST_GX;
      end
      ST_GX: state_nxt = ST_TX;
      ST_TX: state_nxt = ST_VX;
      ST_VX: begin
        vx_nxt    = sat32(72'(vx_r) + 72'(prod_r >>> FRAC_BITS));
        state_nxt = ST_DX;
      end
      ST_DX: state_nxt = ST_DXS;
      ST_DXS: begin
        delta_nxt = sat32(72'(prod_r >>> FRAC_BITS));
        axis_nxt  = 1'b0;
        state_nxt = ST_SW0;
      end
      ST_DY: state_nxt = ST_DYS;
      ST_DYS: begin
        delta_nxt = sat32(72'(prod_r >>> FRAC_BITS));
        axis_nxt  = 1'b1;
        state_nxt = ST_SW0;
      end
      ST_SW0: begin
        if (delta_r == 0) state_nxt = axis_r ? ST_GND : ST_DY;
        else state_nxt = ST_SWW;
      end
      ST_SWW: if (q_rsp.done) begin
        if (q_rsp.blocked) begin
          lo_nxt    = '0;
          hi_nxt    = BW'(1) << BISECT_STEPS;
          it_nxt    = '0;
          state_nxt = ST_BM;
        end else begin
          if (axis_r) cy_nxt = cy_r + PW'(delta_r);
          else cx_nxt = cx_r + PW'(delta_r);
          state_nxt = axis_r ? ST_GND : ST_DY;
        end
      end
      ST_BM: state_nxt = ST_BQ;
      ST_BQ: state_nxt = ST_BW;
      ST_BW: if (q_rsp.done) begin
        if (q_rsp.blocked) hi_nxt = mid;
        else lo_nxt = mid;
        if (it_r == IW'(BISECT_STEPS - 1)) begin
          state_nxt = ST_AM;
        end else begin
          it_nxt    = it_r + 1'b1;
          state_nxt = ST_BM;
        end
      end
      ST_AM: state_nxt = ST_AD;
      ST_AD: begin
        // Advance by the free distance less the skin, same direction only
        if (adv != 0 && adv2 != 0 && (adv2[PW-1] == adv[PW-1]) &&
            (adv[PW-1] == delta_r[31])) begin
          if (axis_r) cy_nxt = cy_r + adv2;
          else cx_nxt = cx_r + adv2;
        end
        if (axis_r) begin
          vy_nxt    = '0;
          hity_nxt  = 1'b1;
          state_nxt = ST_GND;
        end else begin
          vx_nxt    = '0;
          hitx_nxt  = 1'b1;
          state_nxt = ST_DY;
        end
      end
      ST_GND: state_nxt = ST_GW;
      ST_GW: if (q_rsp.done) begin
        gnd_nxt   = q_rsp.blocked;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign load_out = (state_r == ST_OUT) && (!ov_r || out_ch.ready);

  // Output beat handshake
  always_comb begin
    ov_nxt = ov_r;
    if (load_out) ov_nxt = 1'b1;
    else if (out_ch.ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers: capture the beat, then update per step
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= in_ch.cmd;
      ow_r   <= in_ch.platform_one_way;
      cx_r   <= PW'(in_ch.center_x);
      cy_r   <= PW'(in_ch.center_y);
      hx_r   <= in_ch.half_x;
      hy_r   <= in_ch.half_y;
      vx_r   <= in_ch.speed_x;
      vy_r   <= in_ch.speed_y;
      gf_r   <= in_ch.gravity_factor;
      skin_r <= in_ch.skin_width;
      sb_r   <= PW'(in_ch.center_y) - $signed(PW'(in_ch.half_y));
    end else begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
    delta_r <= delta_nxt;
    axis_r  <= axis_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    it_r    <= it_nxt;
    hitx_r  <= hitx_nxt;
    hity_r  <= hity_nxt;
    gnd_r   <= gnd_nxt;
    sts_r   <= sts_nxt;
    prod_r  <= prod_nxt;
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (sts_r == STS_STEPPED) begin
        ocx_r  <= sat32(72'(cx_r));
        ocy_r  <= sat32(72'(cy_r));
        ovx_r  <= vx_r;
        ovy_r  <= vy_r;
        ognd_r <= gnd_r;
        ohx_r  <= hitx_r;
        ohy_r  <= hity_r;
      end else begin
        ocx_r  <= '0;
        ocy_r  <= '0;
        ovx_r  <= '0;
        ovy_r  <= '0;
        ognd_r <= 1'b0;
        ohx_r  <= 1'b0;
        ohy_r  <= 1'b0;
      end
      out_ch.status <= sts_r;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.new_center_x = ocx_r;
  assign out_ch.new_center_y = ocy_r;
  assign out_ch.new_speed_x  = ovx_r;
  assign out_ch.new_speed_y  = ovy_r;
  assign out_ch.grounded     = ognd_r;
  assign out_ch.hit_x        = ohx_r;
  assign out_ch.hit_y        = ohy_r;

  // Checks
  `KAS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_BOXES))
  `KAS_ASSERT_NEXT(a_accept_dec, in_ch.valid && in_ch.ready, state_r == ST_DEC)
  `KAS_ASSERT_NEXT(a_load_valid, load_out, out_ch.valid)
  `KAS_ASSERT_IMPL(a_bisect_order, state_r == ST_BW, lo_r < hi_r)

endmodule
